/* hdl/lkv_pkg.sv */
// Shared sizes, codes and transaction types of the linear key-value table.
package lkv_pkg;

  localparam int DEPTH      = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_ACCESS = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [2:0]            operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lkv_request_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic [1:0]            status;
    logic [CNT_BITS-1:0]   entry_count;
  } lkv_response_t;

  typedef struct packed {
    logic compare;
    logic shift;
    logic append;
    logic update;
  } lkv_cell_ctrl_t;

endpackage

/* hdl/lkv_cell.sv */
// One entry of the table: stored key and value, key match, append, value update and shift towards the head.
module lkv_cell (
  input  logic                          clk,
  input  lkv_pkg::lkv_cell_ctrl_t       ctrl,
  input  logic                          occupied,
  input  logic [lkv_pkg::KEY_BITS-1:0]  probe_key,
  input  logic [lkv_pkg::KEY_BITS-1:0]  new_key,
  input  logic [lkv_pkg::VALUE_BITS-1:0] new_value,
  input  logic [lkv_pkg::KEY_BITS-1:0]  next_key,
  input  logic [lkv_pkg::VALUE_BITS-1:0] next_value,
  output logic [lkv_pkg::KEY_BITS-1:0]  key,
  output logic [lkv_pkg::VALUE_BITS-1:0] value,
  output logic                          match,
  output logic [lkv_pkg::VALUE_BITS-1:0] match_value
);
  import lkv_pkg::*;

  logic hit;

  assign hit = occupied && (key == probe_key);

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match       <= hit;
      match_value <= hit ? value : '0;
    end
    if (ctrl.shift) begin
      key   <= next_key;
      value <= next_value;
    end else if (ctrl.append) begin
      key   <= new_key;
      value <= new_value;
    end else if (ctrl.update) begin
      value <= new_value;
    end
  end

endmodule

/* hdl/linear_key_value_table.sv */
// Top level of the linear key-value table: command control and the row of entry cells.
// At acceptance every cell compares its key with the request key and registers the
// outcome; in the execute step, which waits while a stalled result holds the output
// register, the combined match decides the result and the write, append or shift of
// the cells. The next request is accepted once the result has entered the output
// register, so a new request is not taken before the current one has executed. Keys
// are unique, so at most one cell matches; a removal moves every entry behind the
// match one place towards the head at once, keeping insertion order.
module linear_key_value_table (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   request_valid,
  output logic                   request_stall,
  input  lkv_pkg::lkv_request_t  request,
  output logic                   response_valid,
  input  logic                   response_stall,
  output lkv_pkg::lkv_response_t response
);
  import lkv_pkg::*;

  localparam int GROUPS = 8;
  localparam int GROUP_SIZE = (DEPTH + GROUPS - 1) / GROUPS;

  logic                  busy;
  lkv_request_t          cmd;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic                  accept;
  logic                  execute;

  logic [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [VALUE_BITS-1:0] cell_hit_value [DEPTH];
  logic [DEPTH-1:0]      match_vec;
  lkv_cell_ctrl_t        cell_ctrl  [DEPTH];

  logic                  hit;
  logic                  full;
  logic [VALUE_BITS-1:0] found_value;
  logic [VALUE_BITS-1:0] group_value [GROUPS];
  logic [VALUE_BITS-1:0] new_value;
  logic [VALUE_BITS-1:0] rv;
  logic [1:0]            st;
  logic                  do_append;
  logic                  do_update;
  logic                  do_shift;

  assign request_stall = busy;
  assign accept        = request_valid && !busy;
  assign execute       = busy && !(response_valid && response_stall);

  assign hit  = |match_vec;
  assign full = (count == CNT_BITS'(DEPTH));

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_value[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < DEPTH) begin
          group_value[g] = group_value[g] | cell_hit_value[g * GROUP_SIZE + j];
        end
      end
    end
    found_value = '0;
    for (int g = 0; g < GROUPS; g++) begin
      found_value = found_value | group_value[g];
    end
  end

  always_comb begin
    rv         = '0;
    st         = ST_OK;
    count_next = count;
    do_append  = 1'b0;
    do_update  = 1'b0;
    do_shift   = 1'b0;
    new_value  = (cmd.operation == OP_WRITE) ? cmd.value : '0;
    case (cmd.operation)
      OP_ACCESS, OP_WRITE: begin
        if (hit) begin
          do_update = (cmd.operation == OP_WRITE);
          rv        = (cmd.operation == OP_WRITE) ? cmd.value : found_value;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          do_append  = 1'b1;
          count_next = count + 1'b1;
          rv         = new_value;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          rv = found_value;
        end else begin
          st = ST_ABSENT;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          do_shift   = 1'b1;
          count_next = count - 1'b1;
        end else begin
          st = ST_ABSENT;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DEPTH-1:0]      low_mask;
    logic [KEY_BITS-1:0]   next_key;
    logic [VALUE_BITS-1:0] next_value;

    assign low_mask = {DEPTH{1'b1}} >> (DEPTH - 1 - i);

    if (i == DEPTH - 1) begin : g_last
      assign next_key   = cell_key[i];
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_key   = cell_key[i+1];
      assign next_value = cell_value[i+1];
    end

    always_comb begin
      cell_ctrl[i].compare = accept;
      cell_ctrl[i].shift   = execute && do_shift && (|(match_vec & low_mask));
      cell_ctrl[i].append  = execute && do_append && (count == CNT_BITS'(i));
      cell_ctrl[i].update  = execute && do_update && match_vec[i];
    end

    lkv_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .occupied    (CNT_BITS'(i) < count),
      .probe_key   (request.key),
      .new_key     (cmd.key),
      .new_value   (new_value),
      .next_key    (next_key),
      .next_value  (next_value),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .match       (match_vec[i]),
      .match_value (cell_hit_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      count          <= '0;
      response_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (execute) begin
        busy <= 1'b0;
      end
      if (execute) begin
        count          <= count_next;
        response_valid <= 1'b1;
      end else if (!response_stall) begin
        response_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= request;
    end
    if (execute) begin
      response.read_value  <= rv;
      response.status      <= st;
      response.entry_count <= count_next;
    end
  end

endmodule
